// File: hw/rtl/psc_pkg.sv
// Shared types, constants and the microcode program of the PID speed controller.
package psc_pkg;

  // Datapath operation selected by one control word
  typedef enum logic [2:0] {
    OP_ERR,
    OP_DIV,
    OP_CLAMP,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_OUT
  } op_e;

  // Jump condition of one control word
  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_DIV_BUSY,
    JMP_OUT_FULL
  } jmp_e;

  typedef logic [2:0] pc_t;

  // One control word of the program ROM
  typedef struct packed {
    op_e  op;
    jmp_e jmp;
    pc_t  target;
    logic last;
  } ctrl_t;

  // Configuration register indexes
  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_I = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;

  localparam int unsigned GAIN_W = 16;
  // Quotient bits of the clamp division: the numerator fits in 15 bits
  localparam int unsigned DIV_BITS = 15;
  localparam logic [DIV_BITS-1:0] CLAMP_NUM = 15'd25600;
  // Drive saturates at +/-100.0 in Q8.8
  localparam logic signed [15:0] DRIVE_LIMIT = 16'sd25600;

  // Program: error, serial clamp division, clamp, three products, output
  function automatic ctrl_t rom_word(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_ERR, jmp: JMP_NONE, target: 3'd0, last: 1'b0};
    case (pc)
      3'd0: w = '{op: OP_ERR,   jmp: JMP_NONE,     target: 3'd0, last: 1'b0};
      3'd1: w = '{op: OP_DIV,   jmp: JMP_DIV_BUSY, target: 3'd1, last: 1'b0};
      3'd2: w = '{op: OP_CLAMP, jmp: JMP_NONE,     target: 3'd0, last: 1'b0};
      3'd3: w = '{op: OP_MUL_P, jmp: JMP_NONE,     target: 3'd0, last: 1'b0};
      3'd4: w = '{op: OP_MUL_I, jmp: JMP_NONE,     target: 3'd0, last: 1'b0};
      3'd5: w = '{op: OP_MUL_D, jmp: JMP_NONE,     target: 3'd0, last: 1'b0};
      3'd6: w = '{op: OP_ACC,   jmp: JMP_NONE,     target: 3'd0, last: 1'b0};
      3'd7: w = '{op: OP_OUT,   jmp: JMP_OUT_FULL, target: 3'd7, last: 1'b1};
      default: w = '{op: OP_ERR, jmp: JMP_NONE, target: 3'd0, last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/pid_speed_controller_unit.sv
// Top level of the PID speed controller: microcode sequencer and datapath.
//
// One speed sample pair enters per beat and one saturated Q8.8 drive beat
// leaves for it. For each accepted sample the program runs one error step,
// 15 steps of a bit-serial restoring divider that forms the integral clamp
// 25600/gain_i, one clamp step, three passes through a single shared
// multiplier, one final add and one output step. The input stalls while a
// sample is in work and takes the next sample in the cycle after the result
// is written. The result sits in an output register; when it is still held,
// the output step waits in place. The user must write gains through the
// register port only while the block is idle; the block does not enforce
// this. Writes to an unused index are dropped.
module pid_speed_controller_unit
  import psc_pkg::*;
#(
  parameter int unsigned SPEED_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [GAIN_W-1:0]             cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SPEED_WIDTH-1:0] target_speed_i,
  input  logic signed [SPEED_WIDTH-1:0] measured_speed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            drive_o
);

  // Error, multiplier operand, product and accumulator widths
  localparam int unsigned EW   = SPEED_WIDTH + 1;
  localparam int unsigned MW   = (SPEED_WIDTH + 2 > 16) ? SPEED_WIDTH + 2 : 16;
  localparam int unsigned SUMW = ((EW > 16) ? EW : 16) + 1;
  localparam int unsigned PW   = GAIN_W + 1 + MW;
  localparam int unsigned AW   = PW + 2;
  localparam int unsigned CW   = $clog2(DIV_BITS);
  localparam logic [CW-1:0] DIV_LAST = CW'(DIV_BITS - 1);

  localparam logic signed [AW-1:0] ACC_POS = AW'(DRIVE_LIMIT);
  localparam logic signed [AW-1:0] ACC_NEG = -ACC_POS;

  // Configuration and controller state
  logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [EW-1:0]  last_q, last_d;
  logic signed [15:0]    integ_q, integ_d;

  // Sequencer
  logic  busy_q, busy_d;
  pc_t   pc_q, pc_d;
  ctrl_t cw;
  logic  jump;

  // Datapath registers
  logic signed [SPEED_WIDTH-1:0] tgt_q, meas_q;
  logic signed [EW-1:0]  err_q, err_d;
  logic signed [MW-1:0]  diff_q, diff_d;
  logic [GAIN_W-1:0]     rem_q, rem_d;
  logic [DIV_BITS-1:0]   quo_q, quo_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [15:0]    drive_q, drive_d;

  // Combinational helpers
  logic                  in_take;
  logic                  out_full;
  logic [GAIN_W:0]       trial;
  logic                  q_bit;
  logic signed [SUMW-1:0] sum, lim;
  logic signed [GAIN_W:0] mul_a;
  logic signed [MW-1:0]   mul_b;

  assign in_stall_o  = busy_q;
  assign in_take     = in_valid_i & ~busy_q;
  assign out_full    = out_valid_q & out_stall_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // Fetch control word and pick the next step
  always_comb begin
    cw = rom_word(pc_q);
    case (cw.jmp)
      JMP_DIV_BUSY: jump = (cnt_q != DIV_LAST);
      JMP_OUT_FULL: jump = out_full;
      default:      jump = 1'b0;
    endcase
    busy_d = busy_q;
    pc_d   = pc_q;
    if (in_take) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q) begin
      if (jump) begin
        pc_d = cw.target;
      end else if (cw.last) begin
        busy_d = 1'b0;
        pc_d   = '0;
      end else begin
        pc_d = pc_q + 3'd1;
      end
    end
  end

  // Datapath: one operation per step
  always_comb begin
    last_d      = last_q;
    integ_d     = integ_q;
    err_d       = err_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    drive_d     = drive_q;
    out_valid_d = out_valid_q & out_stall_i;

    trial = {rem_q, quo_q[DIV_BITS-1]};
    q_bit = (trial >= {1'b0, gain_i_q});
    sum   = SUMW'(integ_q) + SUMW'(err_q);
    lim   = SUMW'($signed({1'b0, quo_q}));

    mul_a = $signed({1'b0, gain_p_q});
    mul_b = MW'(err_q);
    case (cw.op)
      OP_MUL_I: begin
        mul_a = $signed({1'b0, gain_i_q});
        mul_b = MW'(integ_q);
      end
      OP_MUL_D: begin
        mul_a = $signed({1'b0, gain_d_q});
        mul_b = diff_q;
      end
      default: begin
        mul_a = $signed({1'b0, gain_p_q});
        mul_b = MW'(err_q);
      end
    endcase

    if (busy_q) begin
      case (cw.op)
        // form error and difference, load divider
        OP_ERR: begin
          err_d  = EW'(tgt_q) - EW'(meas_q);
          diff_d = MW'(err_d) - MW'(last_q);
          last_d = err_d;
          rem_d  = '0;
          quo_d  = CLAMP_NUM;
          cnt_d  = '0;
          acc_d  = '0;
        end
        // one restoring division step
        OP_DIV: begin
          rem_d = q_bit ? GAIN_W'(trial - {1'b0, gain_i_q}) : GAIN_W'(trial);
          quo_d = {quo_q[DIV_BITS-2:0], q_bit};
          cnt_d = cnt_q + CW'(1);
        end
        // add error to integral and clamp, or clear on zero gain
        OP_CLAMP: begin
          if (gain_i_q == '0) begin
            integ_d = '0;
          end else if (sum > lim) begin
            integ_d = 16'(lim);
          end else if (sum < -lim) begin
            integ_d = 16'(-lim);
          end else begin
            integ_d = 16'(sum);
          end
        end
        OP_MUL_P: begin
          prod_d = PW'(mul_a) * PW'(mul_b);
        end
        OP_MUL_I, OP_MUL_D: begin
          acc_d  = acc_q + AW'(prod_q);
          prod_d = PW'(mul_a) * PW'(mul_b);
        end
        OP_ACC: begin
          acc_d = acc_q + AW'(prod_q);
        end
        // saturate and write result when the output register is free
        OP_OUT: begin
          if (!out_full) begin
            out_valid_d = 1'b1;
            if (acc_q > ACC_POS) begin
              drive_d = DRIVE_LIMIT;
            end else if (acc_q < ACC_NEG) begin
              drive_d = -DRIVE_LIMIT;
            end else begin
              drive_d = 16'(acc_q);
            end
          end
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      last_q      <= '0;
      integ_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      integ_q     <= integ_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_P: gain_p_q <= cfg_data_i;
          REG_GAIN_I: gain_i_q <= cfg_data_i;
          REG_GAIN_D: gain_d_q <= cfg_data_i;
          default: begin
            gain_p_q <= gain_p_q;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tgt_q  <= target_speed_i;
      meas_q <= measured_speed_i;
    end
    err_q   <= err_d;
    diff_q  <= diff_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    drive_q <= drive_d;
  end

endmodule

// File: tb/sv/pid_drive_checker.sv
// Drive predictor and beat checker for the PID speed controller testbench.
module pid_drive_checker
  import psc_pkg::*;
#(
  parameter int unsigned SPEED_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [GAIN_W-1:0]             cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [SPEED_WIDTH-1:0] target_speed_i,
  input  logic signed [SPEED_WIDTH-1:0] measured_speed_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [15:0]            drive_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  // Shadow copy of the gains and of the loop state
  logic [GAIN_W-1:0]            gain_p;
  logic [GAIN_W-1:0]            gain_i;
  logic [GAIN_W-1:0]            gain_d;
  logic signed [SPEED_WIDTH:0]  prev_err;
  logic signed [15:0]           integ_sum;

  // Mismatches seen so far
  int fails = 0;

  // Drives predicted for accepted samples, oldest first
  logic signed [15:0] drive_q[$];

  assign fail_count_o = fails;

  // Advance the loop state by one sample and return the saturated drive
  function automatic logic signed [15:0] next_drive(
    input logic signed [SPEED_WIDTH-1:0] tgt,
    input logic signed [SPEED_WIDTH-1:0] meas
  );
    longint err;
    longint lim;
    longint sum;
    longint acc;
    err = longint'(tgt) - longint'(meas);
    // Zero integral gain clears the sum and skips the clamp
    if (gain_i != '0) begin
      lim = longint'(CLAMP_NUM) / longint'(gain_i);
      sum = longint'(integ_sum) + err;
      if (sum > lim) begin
        sum = lim;
      end else if (sum < -lim) begin
        sum = -lim;
      end
      integ_sum = sum[15:0];
    end else begin
      integ_sum = '0;
    end
    acc = longint'(gain_p) * err
        + longint'(gain_i) * longint'(integ_sum)
        + longint'(gain_d) * (err - longint'(prev_err));
    if (acc > longint'(DRIVE_LIMIT)) begin
      acc = longint'(DRIVE_LIMIT);
    end
    if (acc < -longint'(DRIVE_LIMIT)) begin
      acc = -longint'(DRIVE_LIMIT);
    end
    prev_err = err[SPEED_WIDTH:0];
    return acc[15:0];
  endfunction

  // Track gain writes, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [15:0] exp_drive;
    if (!rst_ni) begin
      gain_p    = '0;
      gain_i    = '0;
      gain_d    = '0;
      prev_err  = '0;
      integ_sum = '0;
      drive_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_P: gain_p = cfg_data_i;
          REG_GAIN_I: gain_i = cfg_data_i;
          REG_GAIN_D: gain_d = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        drive_q.push_back(next_drive(target_speed_i, measured_speed_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $display("%0t: drive beat %0d arrived with no sample pending", $time, drive_i);
          fails = fails + 1;
        end else begin
          exp_drive = drive_q.pop_front();
          if (drive_i !== exp_drive) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d",
                     $time, exp_drive, drive_i);
            fails = fails + 1;
          end
        end
      end
      pending_o = drive_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the PID speed controller testbench: clock, reset, stimulus and verdict.
module testbench;
  import psc_pkg::*;

  localparam int unsigned SPEED_W      = 16;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_ITEMS  = 250;
  localparam int          SETTLE_CYC   = 30;
  localparam int          HOLD_AT      = 700;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STUCK_LIMIT  = 3000;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [1:0]                cfg_idx;
  logic [GAIN_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SPEED_W-1:0] target_speed;
  logic signed [SPEED_W-1:0] measured_speed;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [15:0]        drive;

  int  fail_count;
  int  pending;
  int  drive_beats;
  int  sample_beats;
  int  gain_sets;
  bit  idle_en;

  pid_speed_controller_unit #(.SPEED_WIDTH(SPEED_W)) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .target_speed_i  (target_speed),
    .measured_speed_i(measured_speed),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .drive_o         (drive)
  );

  pid_drive_checker #(.SPEED_WIDTH(SPEED_W)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .target_speed_i  (target_speed),
    .measured_speed_i(measured_speed),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .drive_i         (drive),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Write one gain register for a single cycle
  task automatic write_gain(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Offer one sample beat after an optional gap and hold it until accepted
  task automatic send_sample(input logic signed [SPEED_W-1:0] tgt,
                             input logic signed [SPEED_W-1:0] meas);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    target_speed   = tgt;
    measured_speed = meas;
    do @(posedge clk); while (in_stall);
    sample_beats++;
    @(negedge clk);
  endtask

  // Drop valid, drain every predicted drive and let the block go idle
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Pick a gain: mostly moderate, with extremes and clamp corners mixed in
  function automatic logic [GAIN_W-1:0] pick_gain(input bit integral);
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 9))
      0:       g = '0;
      1:       g = '1;
      2, 3:    g = GAIN_W'($urandom);
      4:       g = integral ? GAIN_W'(1) : GAIN_W'(256);
      5:       g = integral ? GAIN_W'($urandom_range(25599, 25601)) : GAIN_W'(512);
      default: g = GAIN_W'($urandom_range(0, 1024));
    endcase
    return g;
  endfunction

  // Send a sample: mostly a tracking loop near its target, plus wide noise
  task automatic send_random();
    int                        mode;
    logic signed [SPEED_W-1:0] tgt;
    logic signed [SPEED_W-1:0] meas;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      tgt  = SPEED_W'(int'($urandom_range(0, 4000)) - 2000);
      meas = tgt + SPEED_W'(int'($urandom_range(0, 200)) - 100);
    end else if (mode < 9) begin
      tgt  = SPEED_W'($urandom);
      meas = SPEED_W'($urandom);
    end else begin
      tgt  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      meas = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    send_sample(tgt, meas);
  endtask

  // Receiver: random stalls around each drive beat, one long hold-off
  initial begin : drain
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (drive_beats == HOLD_AT) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      n = idle_en ? $urandom_range(0, 3) : 0;
      while (n > 0) begin
        out_stall = 1'b1;
        @(posedge clk);
        if (out_valid) n--;
        @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      drive_beats++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("pid_speed_controller_unit regression: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    target_speed   = '0;
    measured_speed = '0;
    drive_beats    = 0;
    sample_beats   = 0;
    gain_sets      = 1;
    idle_en        = 1'b1;
    rst_n          = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Gains at reset are zero, so the drive stays zero
    send_sample(16'sd1000, -16'sd1000);
    send_sample(16'sh7fff, 16'sh8000);
    settle();

    // Unit gains; an unused index must not disturb them
    write_gain(REG_GAIN_P, 16'd256);
    write_gain(REG_GAIN_I, 16'd256);
    write_gain(REG_GAIN_D, 16'd256);
    write_gain(REG_UNUSED, 16'hffff);
    gain_sets++;
    send_sample(16'sd0, 16'sd0);
    repeat (3) send_sample(16'sd100, 16'sd0);
    send_sample(16'sd0, 16'sd100);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(-16'sd1, 16'sd0);
    settle();

    // Zero integral gain clears the sum
    write_gain(REG_GAIN_I, 16'd0);
    gain_sets++;
    repeat (2) send_sample(16'sd50, 16'sd0);
    settle();

    // Integral gain above the clamp numerator gives a zero clamp
    write_gain(REG_GAIN_P, 16'd1);
    write_gain(REG_GAIN_I, 16'd25601);
    write_gain(REG_GAIN_D, 16'd0);
    gain_sets++;
    send_sample(16'sd300, 16'sd0);
    send_sample(-16'sd300, 16'sd0);
    settle();

    // All gains at their maximum
    write_gain(REG_GAIN_P, 16'hffff);
    write_gain(REG_GAIN_I, 16'hffff);
    write_gain(REG_GAIN_D, 16'hffff);
    gain_sets++;
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    settle();

    // Smallest integral gain: the widest clamp, reached at once
    write_gain(REG_GAIN_P, 16'd0);
    write_gain(REG_GAIN_I, 16'd1);
    write_gain(REG_GAIN_D, 16'd0);
    gain_sets++;
    repeat (2) send_sample(16'sh7fff, 16'sh8000);
    settle();

    // Random gain settings, one phase with no idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_gain(REG_GAIN_P, pick_gain(1'b0));
      write_gain(REG_GAIN_I, pick_gain(1'b1));
      write_gain(REG_GAIN_D, pick_gain(1'b0));
      gain_sets++;
      idle_en = (ph != 3);
      repeat (PHASE_ITEMS) send_random();
      settle();
    end

    $display("covered %0d sample beats and %0d drive beats over %0d gain settings",
             sample_beats, drive_beats, gain_sets);
    $display("stimulus included clamp corners, saturation and one long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("pid_speed_controller_unit regression: pass");
    end else begin
      $display("pid_speed_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
